[sv/dexs_pkg.sv]
// ----------------------------------------------------------------------------
// dexs_pkg
// Shared types, constants, arithmetic helpers and the microprogram of the
// double exponential smoother.
// ----------------------------------------------------------------------------
package dexs_pkg;

    // Data format and gain format.
    localparam int DW         = 32;
    localparam int GAIN_SHIFT = 16;
    localparam int GW         = GAIN_SHIFT + 1;
    localparam int PW         = DW + GW;
    localparam logic [GW-1:0] GAIN_ONE = GW'(1) << GAIN_SHIFT;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TREND_GAIN = CFG_IDX_W'(1);
    localparam logic [GW-1:0] GAIN_RESET = GW'(8192);

    // Item modes.
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Samples seen counter values.
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    // Datapath operations.
    localparam logic [2:0] DP_NOP  = 3'd0;
    localparam logic [2:0] DP_INIT = 3'd1;
    localparam logic [2:0] DP_SEED = 3'd2;
    localparam logic [2:0] DP_PROJ = 3'd3;
    localparam logic [2:0] DP_LVL  = 3'd4;
    localparam logic [2:0] DP_DIFF = 3'd5;
    localparam logic [2:0] DP_TRD  = 3'd6;

    // Multiplier gain select.
    localparam logic [1:0] G_ALPHA   = 2'd0;
    localparam logic [1:0] G_ALPHA_C = 2'd1;
    localparam logic [1:0] G_BETA    = 2'd2;
    localparam logic [1:0] G_BETA_C  = 2'd3;

    // Multiplier operand select.
    localparam logic [1:0] M_X   = 2'd0;
    localparam logic [1:0] M_T   = 2'd1;
    localparam logic [1:0] M_TRD = 2'd2;

    // Sequencing.
    localparam logic [1:0] J_NEXT  = 2'd0;
    localparam logic [1:0] J_SEEN0 = 2'd1;
    localparam logic [1:0] J_SEEN2 = 2'd2;
    localparam logic [1:0] J_END   = 2'd3;

    localparam int UC_DEPTH = 10;
    localparam int PC_W     = $clog2(UC_DEPTH);

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DW-1:0]     sample;
    } t_in_item;

    typedef struct packed {
        logic signed [DW-1:0]     level_out;
        logic                     empty_res;
    } t_out_item;

    // One microcode word.
    typedef struct packed {
        logic [2:0]      op;
        logic            mul_en;
        logic [1:0]      gsel;
        logic [1:0]      msrc;
        logic            acc_ld;
        logic [1:0]      jcond;
        logic [PC_W-1:0] target;
    } t_uword;

    // Datapath status seen by the sequencer and the top level.
    typedef struct packed {
        logic [1:0] seen;
    } t_status;

    localparam t_uword UW_NOP = '{op: DP_NOP, mul_en: 1'b0, gsel: G_ALPHA, msrc: M_X,
                                  acc_ld: 1'b0, jcond: J_END, target: '0};

    function automatic t_uword uw(input logic [2:0] op, input logic mul_en,
                                  input logic [1:0] gsel, input logic [1:0] msrc,
                                  input logic acc_ld, input logic [1:0] jcond,
                                  input int target);
        t_uword w;
        w.op     = op;
        w.mul_en = mul_en;
        w.gsel   = gsel;
        w.msrc   = msrc;
        w.acc_ld = acc_ld;
        w.jcond  = jcond;
        w.target = PC_W'(target);
        return w;
    endfunction

    // Add-sample microprogram. Steps 3 to 8 are the Holt update proper.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_W'(0): w = uw(DP_NOP,  1'b0, G_ALPHA,   M_X,   1'b0, J_SEEN0, 9);
            PC_W'(1): w = uw(DP_NOP,  1'b0, G_ALPHA,   M_X,   1'b0, J_SEEN2, 3);
            PC_W'(2): w = uw(DP_SEED, 1'b0, G_ALPHA,   M_X,   1'b0, J_NEXT,  0);
            PC_W'(3): w = uw(DP_PROJ, 1'b1, G_ALPHA,   M_X,   1'b0, J_NEXT,  0);
            PC_W'(4): w = uw(DP_NOP,  1'b1, G_ALPHA_C, M_T,   1'b1, J_NEXT,  0);
            PC_W'(5): w = uw(DP_LVL,  1'b1, G_BETA_C,  M_TRD, 1'b0, J_NEXT,  0);
            PC_W'(6): w = uw(DP_DIFF, 1'b0, G_BETA,    M_X,   1'b1, J_NEXT,  0);
            PC_W'(7): w = uw(DP_NOP,  1'b1, G_BETA,    M_T,   1'b0, J_NEXT,  0);
            PC_W'(8): w = uw(DP_TRD,  1'b0, G_BETA,    M_X,   1'b0, J_END,   0);
            PC_W'(9): w = uw(DP_INIT, 1'b0, G_ALPHA,   M_X,   1'b0, J_END,   0);
            default:  w = UW_NOP;
        endcase
        return w;
    endfunction

    // Saturate a sum two bits wider than the data format.
    function automatic logic signed [DW-1:0] sat(input logic signed [DW+1:0] v);
        logic signed [DW-1:0] r;
        if ((v[DW+1:DW-1] == 3'b000) || (v[DW+1:DW-1] == 3'b111)) begin
            r = v[DW-1:0];
        end else if (v[DW+1]) begin
            r = {1'b1, {(DW-1){1'b0}}};
        end else begin
            r = {1'b0, {(DW-1){1'b1}}};
        end
        return r;
    endfunction

    // Scale a gain product by 2^-16, rounding to nearest, ties upward.
    function automatic logic signed [DW:0] weigh(input logic signed [PW-1:0] p);
        return p[PW-1:GAIN_SHIFT] + $signed({{DW{1'b0}}, p[GAIN_SHIFT-1]});
    endfunction

    // Gains above one are used as one.
    function automatic logic [GW-1:0] clamp_gain(input logic [GW-1:0] g);
        return g[GW-1] ? GAIN_ONE : g;
    endfunction

endpackage

[sv/dexs_sequencer.sv]
// ----------------------------------------------------------------------------
// dexs_sequencer
// Step counter over the microcode table with conditional jumps on the
// number of samples seen.
// ----------------------------------------------------------------------------
module dexs_sequencer import dexs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_uword  o_uword,
    output logic    o_busy
);

    logic            r_busy, n_busy;
    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          w_word;
    logic            w_take;

    assign w_word = ucode(r_pc);

    // Jump decision for the current step.
    always_comb begin
        w_take = ((w_word.jcond == J_SEEN0) && (i_status.seen == SEEN_NONE)) ||
                 ((w_word.jcond == J_SEEN2) && (i_status.seen == SEEN_TWO));
    end

    // Next step and busy flag.
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (r_busy) begin
            if (w_word.jcond == J_END) begin
                n_busy = 1'b0;
                n_pc   = '0;
            end else if (w_take) begin
                n_pc = w_word.target;
            end else begin
                n_pc = r_pc + PC_W'(1);
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_pc   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    // The datapath sees a no-op word while idle.
    assign o_uword = r_busy ? w_word : UW_NOP;
    assign o_busy  = r_busy;

    // The program counter stays inside the table.
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc < PC_W'(UC_DEPTH)))
        else $error("sequencer step out of range");

    // A program only ends at an end step.
    a_end_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(w_word.jcond == J_END))
        else $error("sequencer stopped outside an end step");

endmodule

[sv/dexs_datapath.sv]
// ----------------------------------------------------------------------------
// dexs_datapath
// Level, trend and scratch registers with one shared gain multiplier and a
// saturating accumulator, driven by the microcode word.
// ----------------------------------------------------------------------------
module dexs_datapath import dexs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_uword               i_uword,
    input  logic                 i_load_x,
    input  logic signed [DW-1:0] i_x,
    input  logic                 i_clear,
    input  logic [GW-1:0]        i_level_gain,
    input  logic [GW-1:0]        i_trend_gain,
    output t_status              o_status,
    output logic signed [DW-1:0] o_level
);

    logic signed [DW-1:0] r_level, r_trend, r_x, r_t, r_old;
    logic signed [DW:0]   r_acc;
    logic signed [PW-1:0] r_prod;
    logic [1:0]           r_seen;

    logic [GW-1:0]        w_alpha, w_beta, w_gain;
    logic signed [DW-1:0] w_opnd;
    logic signed [PW:0]   w_full;
    logic signed [DW:0]   w_wt;
    logic signed [DW-1:0] w_accsum;

    assign w_alpha = clamp_gain(i_level_gain);
    assign w_beta  = clamp_gain(i_trend_gain);

    // Multiplier operand selection.
    always_comb begin
        case (i_uword.gsel)
            G_ALPHA:   w_gain = w_alpha;
            G_ALPHA_C: w_gain = GAIN_ONE - w_alpha;
            G_BETA:    w_gain = w_beta;
            G_BETA_C:  w_gain = GAIN_ONE - w_beta;
            default:   w_gain = w_alpha;
        endcase
        case (i_uword.msrc)
            M_X:     w_opnd = r_x;
            M_T:     w_opnd = r_t;
            M_TRD:   w_opnd = r_trend;
            default: w_opnd = r_x;
        endcase
    end

    // Gain times value; the product is registered before any further use.
    assign w_full = $signed({1'b0, w_gain}) * w_opnd;

    // Rounded weighted term and the saturated sum of both terms.
    assign w_wt     = weigh(r_prod);
    assign w_accsum = sat({r_acc[DW], r_acc} + {w_wt[DW], w_wt});

    always_ff @(posedge i_clk) begin
        if (i_uword.mul_en) begin
            r_prod <= w_full[PW-1:0];
        end
        if (i_uword.acc_ld) begin
            r_acc <= w_wt;
        end
        if (i_load_x) begin
            r_x <= i_x;
        end
        case (i_uword.op)
            DP_PROJ: begin
                r_t   <= sat({{2{r_level[DW-1]}}, r_level} + {{2{r_trend[DW-1]}}, r_trend});
                r_old <= r_level;
            end
            DP_DIFF: begin
                r_t <= sat({{2{r_level[DW-1]}}, r_level} - {{2{r_old[DW-1]}}, r_old});
            end
            default: begin
            end
        endcase
    end

    // Architectural state: level, trend and samples seen.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_trend <= '0;
            r_seen  <= SEEN_NONE;
        end else if (i_clear) begin
            r_level <= '0;
            r_trend <= '0;
            r_seen  <= SEEN_NONE;
        end else begin
            case (i_uword.op)
                DP_INIT: begin
                    r_level <= r_x;
                    r_trend <= r_x;
                    r_seen  <= SEEN_ONE;
                end
                DP_SEED: begin
                    r_trend <= sat({{2{r_x[DW-1]}}, r_x} - {{2{r_trend[DW-1]}}, r_trend});
                    r_level <= r_x;
                end
                DP_LVL: begin
                    r_level <= w_accsum;
                end
                DP_TRD: begin
                    r_trend <= w_accsum;
                    r_seen  <= SEEN_TWO;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.seen = r_seen;
    assign o_level       = r_level;

    // The sample counter saturates at two.
    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen != 2'd3)
        else $error("samples seen counter out of range");

endmodule

[sv/double_exponential_smoother.sv]
// ----------------------------------------------------------------------------
// double_exponential_smoother
// Holt level and trend smoother in signed Q16.16 with a query and clear mode.
// ----------------------------------------------------------------------------
// An add item runs a short microprogram on one shared 17 by 32 multiplier,
// one step per cycle: a first sample loads level and trend, a second seeds the
// trend and then runs the update, a later one runs the update directly, with
// its four multiplications and their dependent sums. No item is accepted while
// it runs. A query result sits in an output register, and only a further query
// waits while that result is stalled. The user must write gains through the
// configuration port while the block is idle; the block does not enforce this.
// Values above 65536 act as 1.0.
module double_exponential_smoother import dexs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output t_out_item            o_out_item,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GW-1:0]        i_cfg_data
);

    logic [GW-1:0] r_level_gain, r_trend_gain;
    logic          r_out_valid;
    t_out_item     r_out_item;

    logic          w_busy, w_accept, w_is_add, w_is_query, w_is_clear;
    t_uword        w_uword;
    t_status       w_status;
    logic signed [DW-1:0] w_level;

    // Input handshake: every item waits while an add runs; a query also waits while the previous result is held.
    assign w_is_add   = i_in_item.mode == MODE_ADD;
    assign w_is_query = i_in_item.mode == MODE_QUERY;
    assign w_is_clear = i_in_item.mode == MODE_CLEAR;
    assign o_in_stall = w_busy || (r_out_valid && i_out_stall && i_in_valid && w_is_query);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Gain registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_gain <= GAIN_RESET;
            r_trend_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEVEL_GAIN: r_level_gain <= i_cfg_data;
                REG_TREND_GAIN: r_trend_gain <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dexs_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept && w_is_add),
        .i_status (w_status),
        .o_uword  (w_uword),
        .o_busy   (w_busy)
    );

    dexs_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_uword      (w_uword),
        .i_load_x     (w_accept && w_is_add),
        .i_x          (i_in_item.sample),
        .i_clear      (w_accept && w_is_clear),
        .i_level_gain (r_level_gain),
        .i_trend_gain (r_trend_gain),
        .o_status     (w_status),
        .o_level      (w_level)
    );

    // Output register for query results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_is_query) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_query) begin
            if (w_status.seen == SEEN_NONE) begin
                r_out_item.level_out <= '0;
                r_out_item.empty_res <= 1'b1;
            end else begin
                r_out_item.level_out <= w_level;
                r_out_item.empty_res <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // An accepted add starts the microprogram.
    a_add_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_add) |=> w_busy)
        else $error("add item did not start the sequencer");

    // A result appears only after an accepted query.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_accept && w_is_query))
        else $error("result without a query");

    // A query with no samples reports empty with a zero level.
    a_empty_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_query && (w_status.seen == SEEN_NONE)) |=>
        (o_out_item.empty_res && (o_out_item.level_out == '0)))
        else $error("empty query returned a level");

endmodule

[tb/dexs_checker.sv]
// ----------------------------------------------------------------------------
// dexs_checker
// Watches the item, result and gain ports of the smoother, keeps its own
// level/trend model, and compares every query answer field by field.
// ----------------------------------------------------------------------------
module dexs_checker import dexs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_item,
    input  logic                 i_in_stall,
    input  logic                 i_out_valid,
    input  t_out_item            i_out_item,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GW-1:0]        i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI = (longint'(1) << (DW - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam longint HALF_LSB = longint'(1) << (GAIN_SHIFT - 1);

    // Model of the smoother state and its two gain registers.
    logic signed [DW-1:0] model_level;
    logic signed [DW-1:0] model_trend;
    logic [1:0]           model_seen;
    logic [GW-1:0]        alpha_reg;
    logic [GW-1:0]        beta_reg;

    // Query answers still to come out of the block, oldest first.
    t_out_item query_answers[$];

    // Saturate a wide sum to the signed data format.
    function automatic logic signed [DW-1:0] clip(input longint v);
        if (v > SAT_HI) begin
            return DW'(SAT_HI);
        end else if (v < SAT_LO) begin
            return DW'(SAT_LO);
        end
        return DW'(v);
    endfunction

    // Gain times value scaled down by 2^16, nearest with ties upward.
    function automatic longint scale(input longint g, input longint v);
        return (g * v + HALF_LSB) >>> GAIN_SHIFT;
    endfunction

    // Weighted sum g*a + (1-g)*b, saturated.
    function automatic logic signed [DW-1:0] mix(input longint g, input longint a,
                                                 input longint b);
        return clip(scale(g, a) + scale(longint'(GAIN_ONE) - g, b));
    endfunction

    function automatic longint eff_gain(input logic [GW-1:0] g);
        return (g > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(g);
    endfunction

    // Holt update for one added sample.
    task automatic take_sample(input logic signed [DW-1:0] x);
        logic signed [DW-1:0] prior;
        logic signed [DW-1:0] projected;
        if (model_seen == SEEN_NONE) begin
            model_level = x;
            model_trend = x;
            model_seen  = SEEN_ONE;
        end else begin
            // The second sample seeds the trend from the first before updating.
            if (model_seen == SEEN_ONE) begin
                model_trend = clip(longint'(x) - longint'(model_trend));
                model_level = x;
            end
            prior       = model_level;
            projected   = clip(longint'(model_level) + longint'(model_trend));
            model_level = mix(eff_gain(alpha_reg), x, projected);
            model_trend = mix(eff_gain(beta_reg),
                              clip(longint'(model_level) - longint'(prior)),
                              model_trend);
            model_seen  = SEEN_TWO;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item answer;
        if (!i_rst_n) begin
            alpha_reg   = GAIN_RESET;
            beta_reg    = GAIN_RESET;
            model_level = '0;
            model_trend = '0;
            model_seen  = SEEN_NONE;
            query_answers.delete();
            o_errors    = 0;
            o_checked   = 0;
        end else begin
            // Results leave from a register, so compare before taking new items.
            if (i_out_valid && !i_out_stall) begin
                if (query_answers.size() == 0) begin
                    $error("level result %0d arrived with no query pending",
                           i_out_item.level_out);
                    o_errors++;
                end else begin
                    want = query_answers.pop_front();
                    if (i_out_item.level_out !== want.level_out) begin
                        $error("level_out: expected %0d, got %0d",
                               want.level_out, i_out_item.level_out);
                        o_errors++;
                    end
                    if (i_out_item.empty_res !== want.empty_res) begin
                        $error("empty_res: expected %0b, got %0b",
                               want.empty_res, i_out_item.empty_res);
                        o_errors++;
                    end
                    o_checked++;
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LEVEL_GAIN: alpha_reg = i_cfg_data;
                    REG_TREND_GAIN: beta_reg  = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                case (i_in_item.mode)
                    MODE_ADD: take_sample(i_in_item.sample);
                    MODE_QUERY: begin
                        answer.empty_res = (model_seen == SEEN_NONE);
                        answer.level_out = answer.empty_res ? '0 : model_level;
                        query_answers.push_back(answer);
                    end
                    MODE_CLEAR: begin
                        model_level = '0;
                        model_trend = '0;
                        model_seen  = SEEN_NONE;
                    end
                    // The unused mode leaves everything as it is.
                    default: ;
                endcase
            end
        end
        o_pending = query_answers.size();
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives the double exponential smoother with directed and random items under
// several gain settings and idle/stall patterns; a checker predicts results.
// ----------------------------------------------------------------------------
module tb_top import dexs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic signed [DW-1:0] Q_MAX   = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] Q_MIN   = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] Q_UNITY = 32'sh0001_0000;
    localparam int SETTLE_CYCLES = 16;
    localparam int GAIN_SETTINGS = 8;
    localparam int ITEMS_PER_SETTING = 160;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    t_in_item             in_item;
    logic                 in_stall;
    logic                 out_valid;
    t_out_item            out_item;
    logic                 out_stall;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [GW-1:0]        cfg_data;

    int chk_errors;
    int chk_pending;
    int chk_checked;

    int send_idle_pct;
    int sink_stall_pct;
    int count_add, count_query, count_clear, count_unused;
    int ramp_at, ramp_step;

    // Gain plan: zero, one, above one, mixed, then random entries.
    logic [GW-1:0] alpha_plan [GAIN_SETTINGS] = '{17'd0, 17'd65536, 17'd131071, 17'd0,
                                                  17'd65536, 17'd70000, 17'd0, 17'd0};
    logic [GW-1:0] beta_plan  [GAIN_SETTINGS] = '{17'd0, 17'd65536, 17'd131071, 17'd65536,
                                                  17'd0, 17'd1, 17'd0, 17'd0};

    double_exponential_smoother dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_item  (in_item),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_item (out_item),
        .i_out_stall(out_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    dexs_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_item  (in_item),
        .i_in_stall (in_stall),
        .i_out_valid(out_valid),
        .i_out_item (out_item),
        .i_out_stall(out_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending),
        .o_checked  (chk_checked)
    );

    // 10 ns clock.
    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver stalls at random with the current probability.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Offer one item after a random idle gap and hold it until accepted.
    // Starts and returns at a falling edge.
    task automatic push_item(input logic [1:0] mode, input logic signed [DW-1:0] value);
        t_in_item item;
        item.mode   = mode;
        item.sample = value;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        case (mode)
            MODE_ADD:   count_add++;
            MODE_QUERY: count_query++;
            MODE_CLEAR: count_clear++;
            default:    count_unused++;
        endcase
    endtask

    // Stop sending until every query has been answered, then let an add finish.
    task automatic drain();
        in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GW-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        int unsigned pick;
        logic [1:0] mode;
        logic signed [DW-1:0] value;
        int setting;
        int n;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        count_add      = 0;
        count_query    = 0;
        count_clear    = 0;
        count_unused   = 0;
        ramp_at        = 0;
        ramp_step      = 32'sh0000_4000;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset gains: empty queries, full-scale samples,
        // trend saturation on the second sample, clears and the unused mode.
        push_item(MODE_QUERY, Q_MAX);
        push_item(MODE_ADD, Q_MAX);
        push_item(MODE_QUERY, '0);
        push_item(MODE_ADD, Q_MIN);
        push_item(MODE_QUERY, '0);
        push_item(MODE_ADD, Q_MIN);
        push_item(MODE_ADD, Q_MAX);
        push_item(MODE_QUERY, Q_MIN);
        push_item(MODE_CLEAR, Q_MAX);
        push_item(MODE_QUERY, '0);
        push_item(MODE_UNUSED, '1);
        push_item(MODE_QUERY, '0);
        push_item(MODE_ADD, '0);
        push_item(MODE_ADD, 32'sd1);
        push_item(MODE_ADD, '1);
        push_item(MODE_QUERY, '0);
        push_item(MODE_UNUSED, Q_MAX);
        push_item(MODE_QUERY, '0);
        push_item(MODE_CLEAR, '0);
        push_item(MODE_ADD, Q_UNITY);
        push_item(MODE_QUERY, '0);
        push_item(MODE_CLEAR, '0);
        push_item(MODE_CLEAR, '1);
        push_item(MODE_QUERY, '1);

        alpha_plan[6] = GW'($urandom_range(0, 65536));
        beta_plan[6]  = GW'($urandom_range(0, 65536));
        alpha_plan[7] = GW'($urandom_range(0, 131071));
        beta_plan[7]  = GW'($urandom_range(0, 65536));

        // Random part: one gain setting and one idle pattern per phase.
        for (setting = 0; setting < GAIN_SETTINGS; setting++) begin
            drain();
            write_gain(REG_LEVEL_GAIN, alpha_plan[setting]);
            write_gain(REG_TREND_GAIN, beta_plan[setting]);
            case (setting % 4)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 74; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 74; end
                default: begin send_idle_pct = 35; sink_stall_pct = 35; end
            endcase

            for (n = 0; n < ITEMS_PER_SETTING; n++) begin
                // Mostly adds and queries so the trend runs long between clears.
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    mode = MODE_ADD;
                end else if (pick < 91) begin
                    mode = MODE_QUERY;
                end else if (pick < 96) begin
                    mode = MODE_CLEAR;
                end else begin
                    mode = MODE_UNUSED;
                end

                // Samples: extremes, full random, mid range, or a noisy ramp.
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    case ($urandom_range(0, 3))
                        0: value = Q_MAX;
                        1: value = Q_MIN;
                        2: value = '0;
                        default: value = '1;
                    endcase
                end else if (pick < 35) begin
                    value = $urandom();
                end else if (pick < 60) begin
                    value = DW'(int'($urandom_range(0, 24'hFF_FFFF)) - 32'sh0080_0000);
                end else begin
                    ramp_at = ramp_at + ramp_step;
                    value   = ramp_at + int'($urandom_range(0, 4095)) - 2048;
                end

                if (mode == MODE_CLEAR) begin
                    ramp_step = int'($urandom_range(0, 1 << 18)) - (1 << 17);
                    ramp_at   = $urandom();
                end

                push_item(mode, value);

                // Now and then the sender waits for every answer.
                if ($urandom_range(0, 199) == 0) begin
                    drain();
                end
            end
        end

        drain();

        $display("Sent %0d items: %0d adds, %0d queries, %0d clears, %0d unused mode;",
                 count_add + count_query + count_clear + count_unused,
                 count_add, count_query, count_clear, count_unused);
        $display("checked %0d level results over %0d gain settings and four idle patterns.",
                 chk_checked, GAIN_SETTINGS + 1);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[double_exponential_smoother.f]
sv/dexs_pkg.sv
sv/dexs_sequencer.sv
sv/dexs_datapath.sv
sv/double_exponential_smoother.sv
tb/dexs_checker.sv
tb/tb_top.sv
